// ===== hw/rtl/fp16dp_pkg.sv =====
// Shared constants and half-precision decode helpers for the fused dot product.
package fp16dp_pkg;

    localparam int LANES      = 8;
    localparam int IN_LANES   = 8;
    localparam int HALF_W     = 16;
    localparam int SIG_W      = 11;
    localparam int PROD_W     = 2 * SIG_W;
    localparam int EXP_W      = 7;
    localparam int PTERM_W    = PROD_W + 4;
    localparam int ATERM_W    = SIG_W + 14;
    localparam int SUM_W      = 32;
    localparam int MAG_W      = 30;
    localparam int MSB_W      = 5;
    localparam int S_TDATA_W  = 4 * 64 + HALF_W;

    localparam logic signed [EXP_W-1:0] EXP_FLOOR   = -7'sd21;
    localparam logic [HALF_W-1:0]       HALF_QNAN   = 16'h7e00;
    localparam logic [HALF_W-1:0]       HALF_INF    = 16'h7c00;
    localparam logic [HALF_W-1:0]       HALF_SIGN   = 16'h8000;

    function automatic logic is_special(input logic [HALF_W-1:0] h);
        return h[14:10] == 5'h1f;
    endfunction

    function automatic logic is_nonzero(input logic [HALF_W-1:0] h);
        return h[14:0] != 15'h0;
    endfunction

    function automatic logic [SIG_W-1:0] half_sig(input logic [HALF_W-1:0] h);
        return {(h[14:10] != 5'h0), h[9:0]};
    endfunction

    // Exponent with subnormals clamped to -14.
    function automatic logic signed [EXP_W-1:0] half_exp(input logic [HALF_W-1:0] h);
        logic signed [EXP_W-1:0] e;
        e = (h[14:10] == 5'h0) ? -7'sd14
                               : $signed({2'b00, h[14:10]}) - 7'sd15;
        return e;
    endfunction

endpackage

// ===== hw/rtl/fp16_fused_dot_product8.sv =====
// Top level of the pipelined fp16 fused dot product with accumulate.
//
// Usage: one transaction on the s_ side carries eight pairs of half operands
// and a half addend; one transaction on the m_ side returns the fused sum
// rounded once to half (round to nearest even) and a flag in m_tuser that is
// set when any operand was infinite or NaN, in which case m_tdata is 0x7e00.
// The block is a six-stage pipeline: decode and lane multiply, maximum
// exponent, alignment, signed sum, magnitude and leading-one search, then
// rounding into the output register. One transaction can be accepted every
// cycle while the pipeline is not stalled, and each result moves through the
// stage registers in that order.
// Throughput is set by the stage enable: all stages advance together when the
// output register is empty or being taken. When the receiver holds m_tready
// low with a result waiting, the whole pipeline holds its contents and
// s_tready goes low; nothing is dropped or repeated. Reset (rst_n low,
// asynchronous) clears all valid bits, so the pipeline starts empty.
module fp16_fused_dot_product8
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // left_lanes_low, left_lanes_high, right_lanes_low, right_lanes_high,
    // addend_half (lowest bit up)
    input  logic [fp16dp_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // sum_half
    output logic [fp16dp_pkg::HALF_W-1:0]    m_tdata,
    // invalid_operand
    output logic [0:0]                       m_tuser
);

    localparam int L  = fp16dp_pkg::LANES;
    localparam int HW = fp16dp_pkg::HALF_W;
    localparam int EW = fp16dp_pkg::EXP_W;

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // Stage 1 registers
    logic [fp16dp_pkg::PROD_W-1:0]  prod1_reg [L];
    logic signed [EW-1:0]           pe1_reg   [L];
    logic [L-1:0]                   pnz1_reg, psg1_reg;
    logic [fp16dp_pkg::SIG_W-1:0]   asig1_reg;
    logic signed [EW-1:0]           aex1_reg;
    logic                           anz1_reg, asg1_reg, bad1_reg;

    // Stage 2 registers
    logic [fp16dp_pkg::PROD_W-1:0]  prod2_reg [L];
    logic signed [EW-1:0]           pe2_reg   [L];
    logic [L-1:0]                   pnz2_reg, psg2_reg;
    logic [fp16dp_pkg::SIG_W-1:0]   asig2_reg;
    logic signed [EW-1:0]           aex2_reg, me2_reg;
    logic                           anz2_reg, asg2_reg, bad2_reg;

    // Stage 3 registers
    logic signed [fp16dp_pkg::SUM_W-1:0] term3_reg [L+1];
    logic signed [EW-1:0]                me3_reg;
    logic                                bad3_reg;

    // Stage 4 registers
    logic signed [fp16dp_pkg::SUM_W-1:0] sum4_reg;
    logic signed [EW-1:0]                me4_reg;
    logic                                bad4_reg;

    // Stage 5 registers
    logic [fp16dp_pkg::MAG_W-1:0] mag5_reg;
    logic [fp16dp_pkg::MSB_W-1:0] msb5_reg;
    logic signed [EW-1:0]         me5_reg;
    logic                         neg5_reg, nz5_reg, bad5_reg;

    // Stage 6 (output) registers
    logic [HW-1:0] out6_reg;
    logic          bad6_reg;

    assign adv      = !v6_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = v6_reg;
    assign m_tdata  = out6_reg;
    assign m_tuser  = bad6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // ---------------- Stage 1: decode and multiply ----------------
    logic [fp16dp_pkg::PROD_W-1:0] prod1_next [L];
    logic signed [EW-1:0]          pe1_next   [L];
    logic [L-1:0]                  pnz1_next, psg1_next;
    logic                          bad1_next;
    logic [HW-1:0]                 addend;

    assign addend = s_tdata[4*64 +: HW];

    always_comb
    begin
        logic [HW-1:0] a, b;
        bad1_next = fp16dp_pkg::is_special(addend);
        for (int i = 0; i < L; i++)
        begin
            if (i < fp16dp_pkg::IN_LANES)
            begin
                a = s_tdata[HW*i +: HW];
                b = s_tdata[128 + HW*i +: HW];
            end
            else
            begin
                a = '0;
                b = '0;
            end
            if (fp16dp_pkg::is_special(a) || fp16dp_pkg::is_special(b))
                bad1_next = 1'b1;
            pnz1_next[i] = fp16dp_pkg::is_nonzero(a) && fp16dp_pkg::is_nonzero(b);
            psg1_next[i] = a[15] ^ b[15];
            prod1_next[i] = fp16dp_pkg::half_sig(a) * fp16dp_pkg::half_sig(b);
            pe1_next[i] = fp16dp_pkg::half_exp(a) + fp16dp_pkg::half_exp(b);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod1_reg <= prod1_next;
            pe1_reg   <= pe1_next;
            pnz1_reg  <= pnz1_next;
            psg1_reg  <= psg1_next;
            asig1_reg <= fp16dp_pkg::half_sig(addend);
            aex1_reg  <= fp16dp_pkg::half_exp(addend);
            anz1_reg  <= fp16dp_pkg::is_nonzero(addend);
            asg1_reg  <= addend[15];
            bad1_reg  <= bad1_next;
        end
    end

    // ---------------- Stage 2: largest exponent ----------------
    logic signed [EW-1:0] me2_next;

    always_comb
    begin
        me2_next = anz1_reg ? aex1_reg : fp16dp_pkg::EXP_FLOOR;
        for (int i = 0; i < L; i++)
        begin
            if (pnz1_reg[i] && (pe1_reg[i] > me2_next))
                me2_next = pe1_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod2_reg <= prod1_reg;
            pe2_reg   <= pe1_reg;
            pnz2_reg  <= pnz1_reg;
            psg2_reg  <= psg1_reg;
            asig2_reg <= asig1_reg;
            aex2_reg  <= aex1_reg;
            anz2_reg  <= anz1_reg;
            asg2_reg  <= asg1_reg;
            me2_reg   <= me2_next;
            bad2_reg  <= bad1_reg;
        end
    end

    // ---------------- Stage 3: alignment ----------------
    logic signed [fp16dp_pkg::SUM_W-1:0] term3_next [L+1];

    always_comb
    begin
        logic signed [EW-1:0]             d;
        logic [fp16dp_pkg::PTERM_W-1:0]   pt;
        logic [fp16dp_pkg::ATERM_W-1:0]   at;
        for (int i = 0; i < L; i++)
        begin
            d  = me2_reg - pe2_reg[i];
            pt = {prod2_reg[i], 4'b0000} >> d[5:0];
            if (!pnz2_reg[i])
                term3_next[i] = '0;
            else if (psg2_reg[i])
                term3_next[i] = -$signed({{(fp16dp_pkg::SUM_W-fp16dp_pkg::PTERM_W){1'b0}}, pt});
            else
                term3_next[i] = $signed({{(fp16dp_pkg::SUM_W-fp16dp_pkg::PTERM_W){1'b0}}, pt});
        end
        d  = me2_reg - aex2_reg;
        at = {asig2_reg, 14'b0} >> d[5:0];
        if (!anz2_reg)
            term3_next[L] = '0;
        else if (asg2_reg)
            term3_next[L] = -$signed({{(fp16dp_pkg::SUM_W-fp16dp_pkg::ATERM_W){1'b0}}, at});
        else
            term3_next[L] = $signed({{(fp16dp_pkg::SUM_W-fp16dp_pkg::ATERM_W){1'b0}}, at});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            term3_reg <= term3_next;
            me3_reg   <= me2_reg;
            bad3_reg  <= bad2_reg;
        end
    end

    // ---------------- Stage 4: sum ----------------
    logic signed [fp16dp_pkg::SUM_W-1:0] sum4_next;

    always_comb
    begin
        sum4_next = '0;
        for (int i = 0; i <= L; i++)
            sum4_next = sum4_next + term3_reg[i];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum4_reg <= sum4_next;
            me4_reg  <= me3_reg;
            bad4_reg <= bad3_reg;
        end
    end

    // ---------------- Stage 5: magnitude and leading one ----------------
    logic [fp16dp_pkg::SUM_W-1:0] abs5;
    logic [fp16dp_pkg::MSB_W-1:0] msb5_next;

    assign abs5 = sum4_reg[fp16dp_pkg::SUM_W-1] ? 32'(-sum4_reg) : 32'(sum4_reg);

    always_comb
    begin
        msb5_next = '0;
        for (int i = 0; i < fp16dp_pkg::MAG_W; i++)
        begin
            if (abs5[i])
                msb5_next = fp16dp_pkg::MSB_W'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag5_reg <= abs5[fp16dp_pkg::MAG_W-1:0];
            msb5_reg <= msb5_next;
            me5_reg  <= me4_reg;
            neg5_reg <= sum4_reg[fp16dp_pkg::SUM_W-1];
            nz5_reg  <= sum4_reg != '0;
            bad5_reg <= bad4_reg;
        end
    end

    // ---------------- Stage 6: round and pack ----------------
    logic [HW-1:0] out6_next;

    // The right shift is the larger of the normal shift (msb - 10) and the
    // subnormal shift (-max_e). Packing as (shift + max_e) << 10 plus the
    // rounded significand lets a rounding carry step the exponent by itself.
    always_comb
    begin
        logic signed [EW-1:0] sn, ss, s;
        logic [fp16dp_pkg::SUM_W-1:0] t, r, h, m;
        logic [20:0] bits;
        sn = $signed({2'b00, msb5_reg}) - 7'sd10;
        ss = -me5_reg;
        s  = (sn > ss) ? sn : ss;
        m  = {{(fp16dp_pkg::SUM_W-fp16dp_pkg::MAG_W){1'b0}}, mag5_reg};
        r  = '0;
        h  = '0;
        if (s < 0)
        begin
            t = m << (-s);
        end
        else if (s == 0)
        begin
            t = m;
        end
        else
        begin
            t = m >> s;
            r = m & ((32'd1 << s) - 32'd1);
            h = 32'd1 << (s - 7'sd1);
            if ((r > h) || ((r == h) && t[0]))
                t = t + 32'd1;
        end
        bits = {11'(s + me5_reg), 10'b0} + 21'(t[17:0]);
        if (bits >= 21'(fp16dp_pkg::HALF_INF))
            bits = 21'(fp16dp_pkg::HALF_INF);
        if (bad5_reg)
            out6_next = fp16dp_pkg::HALF_QNAN;
        else if (!nz5_reg)
            out6_next = '0;
        else
            out6_next = bits[HW-1:0] | (neg5_reg ? fp16dp_pkg::HALF_SIGN : '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out6_reg <= out6_next;
            bad6_reg <= bad5_reg;
        end
    end

    // ---------------- Assertions ----------------
    a_flag_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == fp16dp_pkg::HALF_QNAN)
        else $error("invalid flag without quiet NaN result");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow the stage enable");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(v5_reg) && $stable(v1_reg))
        else $error("pipeline moved while stalled");

endmodule
